/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent assertion sampled on the rising clock, off while reset is low.
`define ERT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same, but the property holds during reset too.
`define ERT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

/* hw/rtl/ert_pkg.sv */
// Types and constants for the epoch reclamation tracker.
package ert_pkg;
  localparam int THREADS_DEF      = 128;
  localparam int BIN_DEPTH_DEF    = 32;
  localparam int HANDLE_WIDTH_DEF = 32;
  localparam int EPOCH_W          = 32;
  localparam int TID_W            = 7;
  localparam int HANDLE_PORT_W    = 32;
  localparam int CFG_W            = 8;
  localparam int EPOCH_BINS       = 3;

  typedef enum logic [1:0] {
    OP_ENTER   = 2'd0,
    OP_EXIT    = 2'd1,
    OP_RETIRE  = 2'd2,
    OP_ADVANCE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_RETIRE_FULL = 2'd1,
    ST_ADV_REFUSED = 2'd2
  } status_t;

  // One classified request waiting in the queue.
  typedef struct packed {
    op_t                      op;
    logic [TID_W-1:0]         tid;
    logic [HANDLE_PORT_W-1:0] handle;
  } req_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic valid;
    req_t req;
  } q_head_t;

  // Back end to front end control.
  typedef struct packed {
    logic pop;
    logic clr_done;
  } back_ctl_t;
endpackage

/* hw/rtl/epoch_reclamation_tracker.sv */
// Top level of the three-epoch reclamation tracker.
// Enter, exit and retire requests are carried out by the back end once at
// the queue head; a two-entry request queue decouples the input side.
// A try-advance request scans the thread table through its one read port,
// one thread per cycle, over the smaller of the configured thread count
// and THREADS. When no active thread lags behind the epoch, it advances
// the epoch and reads each reclaimed handle from the bin memory.
// After reset a clearing pass marks every thread inactive; no request is
// accepted until it finishes, while configuration writes are taken at
// any time.
module epoch_reclamation_tracker #(
  parameter int THREADS      = ert_pkg::THREADS_DEF,
  parameter int BIN_DEPTH    = ert_pkg::BIN_DEPTH_DEF,
  parameter int HANDLE_WIDTH = ert_pkg::HANDLE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ert_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_mode,
  input  logic [ert_pkg::TID_W-1:0]         in_thread_id,
  input  logic [ert_pkg::HANDLE_PORT_W-1:0] in_handle,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_status,
  output logic                              out_advanced,
  output logic                              out_freed_valid,
  output logic [ert_pkg::HANDLE_PORT_W-1:0] out_freed_handle,
  output logic [ert_pkg::EPOCH_W-1:0]       out_epoch_now,
  output logic                              out_last
);
  import ert_pkg::*;

  q_head_t   head;
  back_ctl_t ctl;

  ert_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_mode, .in_thread_id, .in_handle,
    .ctl, .head
  );

  ert_back #(
    .THREADS(THREADS), .BIN_DEPTH(BIN_DEPTH), .HANDLE_WIDTH(HANDLE_WIDTH)
  ) u_back (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_data, .head, .ctl,
    .out_valid, .out_ready, .out_status, .out_advanced, .out_freed_valid,
    .out_freed_handle, .out_epoch_now, .out_last
  );
endmodule

/* hw/rtl/ert_ram.sv */
// Generic single write, single read RAM with registered read data.
module ert_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

/* hw/rtl/ert_front.sv */
// Front end: accepts requests, classifies the mode and queues them.
module ert_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_mode,
  input  logic [ert_pkg::TID_W-1:0]         in_thread_id,
  input  logic [ert_pkg::HANDLE_PORT_W-1:0] in_handle,
  input  ert_pkg::back_ctl_t                ctl,
  output ert_pkg::q_head_t                  head
);
  import ert_pkg::*;

  req_t       q_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       pop;
  req_t       req_in;

  // Classify the incoming request; the mode field maps directly onto the operation codes.
  always_comb begin
    req_in.tid    = in_thread_id;
    req_in.handle = in_handle;
    req_in.op     = op_t'(in_mode);
  end

  // No request is taken while the thread table is being cleared.
  assign in_ready = (cnt_r != 2'd2) && ctl.clr_done;
  assign push     = in_valid && in_ready;
  assign pop      = ctl.pop && (cnt_r != 2'd0);

  // Pointer and count update.
  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= req_in;
    end
  end

  assign head.valid = (cnt_r != 2'd0);
  assign head.req   = q_r[rptr_r];
endmodule

/* hw/rtl/ert_back.sv */
// Back end: thread table, epoch, retire bins, scan and drain sequencer.
module ert_back #(
  parameter int THREADS      = ert_pkg::THREADS_DEF,
  parameter int BIN_DEPTH    = ert_pkg::BIN_DEPTH_DEF,
  parameter int HANDLE_WIDTH = ert_pkg::HANDLE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ert_pkg::CFG_W-1:0]         cfg_data,
  input  ert_pkg::q_head_t                  head,
  output ert_pkg::back_ctl_t                ctl,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_status,
  output logic                              out_advanced,
  output logic                              out_freed_valid,
  output logic [ert_pkg::HANDLE_PORT_W-1:0] out_freed_handle,
  output logic [ert_pkg::EPOCH_W-1:0]       out_epoch_now,
  output logic                              out_last
);
  import ert_pkg::*;

  localparam int TA_W   = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int NW     = $clog2(THREADS + 1);
  localparam int FW     = $clog2(BIN_DEPTH + 1);
  localparam int BDEPTH = EPOCH_BINS * BIN_DEPTH;
  localparam int BA_W   = $clog2(BDEPTH);
  localparam int SW     = (HANDLE_WIDTH < HANDLE_PORT_W) ? HANDLE_WIDTH : HANDLE_PORT_W;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_DRAIN = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  logic [TA_W-1:0]      clr_idx_r, clr_idx_nxt;
  logic [EPOCH_W-1:0]   epoch_r, epoch_nxt;
  logic [1:0]           emod3_r, emod3_nxt;
  logic                 matured_r, matured_nxt;
  logic [FW-1:0]        fill_r [EPOCH_BINS];
  logic [FW-1:0]        fill_nxt [EPOCH_BINS];
  logic [NW-1:0]        scan_idx_r, scan_idx_nxt;
  logic [NW-1:0]        scan_n_r, scan_n_nxt;
  logic                 chk_vld_r, chk_vld_nxt;
  logic [1:0]           bin_r, bin_nxt;
  logic [FW-1:0]        cnt_r, cnt_nxt;
  logic [FW-1:0]        j_r, j_nxt;
  logic                 rd_pend_r, rd_pend_nxt;
  logic [CFG_W-1:0]     act_thr_r;

  logic                 t_we, t_re;
  logic [TA_W-1:0]      t_waddr, t_raddr;
  logic [2:0]           t_wdata, t_rdata;
  logic                 b_we, b_re;
  logic [BA_W-1:0]      b_waddr, b_raddr;
  logic [SW-1:0]        b_wdata, b_rdata;
  logic [BA_W-1:0]      base_cur, base_bin;

  logic                 out_valid_r;
  logic [1:0]           out_status_r;
  logic                 out_adv_r, out_fv_r, out_last_r;
  logic [SW-1:0]        out_fh_r;
  logic [EPOCH_W-1:0]   out_epoch_r;
  logic                 out_free, out_ld;
  status_t              ld_status;
  logic                 ld_adv, ld_fv, ld_last;
  logic [SW-1:0]        ld_fh;
  logic                 tid_ok, lag;

  ert_ram #(.WIDTH(3), .DEPTH(THREADS), .AW(TA_W)) u_thr_ram (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .re(t_re), .raddr(t_raddr), .rdata(t_rdata)
  );

  ert_ram #(.WIDTH(SW), .DEPTH(BDEPTH), .AW(BA_W)) u_bin_ram (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .re(b_re), .raddr(b_raddr), .rdata(b_rdata)
  );

  // Configuration register, always ready.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_thr_r <= '0;
    end else if (cfg_valid) begin
      act_thr_r <= cfg_data;
    end
  end

  // Bin base addresses in the shared bin memory.
  always_comb begin
    case (emod3_r)
      2'd0:    base_cur = '0;
      2'd1:    base_cur = BA_W'(BIN_DEPTH);
      default: base_cur = BA_W'(2 * BIN_DEPTH);
    endcase
    case (bin_r)
      2'd0:    base_bin = '0;
      2'd1:    base_bin = BA_W'(BIN_DEPTH);
      default: base_bin = BA_W'(2 * BIN_DEPTH);
    endcase
  end

  assign out_free = !out_valid_r || out_ready;
  assign tid_ok   = (32'(head.req.tid) < THREADS);
  assign lag      = t_rdata[2] && (t_rdata[1:0] != epoch_r[1:0]);

  // Sequencer.
  always_comb begin
    state_nxt    = state_r;
    clr_idx_nxt  = clr_idx_r;
    epoch_nxt    = epoch_r;
    emod3_nxt    = emod3_r;
    matured_nxt  = matured_r;
    fill_nxt     = fill_r;
    scan_idx_nxt = scan_idx_r;
    scan_n_nxt   = scan_n_r;
    chk_vld_nxt  = chk_vld_r;
    bin_nxt      = bin_r;
    cnt_nxt      = cnt_r;
    j_nxt        = j_r;
    rd_pend_nxt  = rd_pend_r;
    ctl.pop      = 1'b0;
    ctl.clr_done = (state_r != S_CLEAR);
    t_we         = 1'b0;
    t_waddr      = TA_W'(head.req.tid);
    t_wdata      = '0;
    t_re         = 1'b0;
    t_raddr      = scan_idx_r[TA_W-1:0];
    b_we         = 1'b0;
    b_waddr      = base_cur + BA_W'(fill_r[emod3_r]);
    b_wdata      = head.req.handle[SW-1:0];
    b_re         = 1'b0;
    b_raddr      = base_bin + BA_W'(j_r);
    out_ld       = 1'b0;
    ld_status    = ST_OK;
    ld_adv       = 1'b0;
    ld_fv        = 1'b0;
    ld_fh        = '0;
    ld_last      = 1'b1;

    case (state_r)
      // Sweep the thread table to inactive after reset.
      S_CLEAR: begin
        t_we    = 1'b1;
        t_waddr = clr_idx_r;
        t_wdata = '0;
        if (clr_idx_r == TA_W'(THREADS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + TA_W'(1);
        end
      end
      // Carry out the request at the queue head.
      S_IDLE: begin
        if (head.valid && out_free) begin
          ctl.pop = 1'b1;
          case (head.req.op)
            OP_ENTER, OP_EXIT: begin
              t_we    = tid_ok;
              t_wdata = {(head.req.op == OP_ENTER), epoch_r[1:0]};
              out_ld  = 1'b1;
            end
            OP_RETIRE: begin
              out_ld = 1'b1;
              if (32'(fill_r[emod3_r]) >= BIN_DEPTH) begin
                ld_status = ST_RETIRE_FULL;
              end else begin
                b_we              = 1'b1;
                fill_nxt[emod3_r] = fill_r[emod3_r] + FW'(1);
              end
            end
            default: begin
              scan_idx_nxt = '0;
              chk_vld_nxt  = 1'b0;
              scan_n_nxt   = (32'(act_thr_r) > THREADS) ? NW'(THREADS) : NW'(act_thr_r);
              state_nxt    = S_SCAN;
            end
          endcase
        end
      end
      // Check one thread per cycle for an active slot behind the epoch.
      S_SCAN: begin
        if (chk_vld_r && lag) begin
          if (out_free) begin
            out_ld      = 1'b1;
            ld_status   = ST_ADV_REFUSED;
            chk_vld_nxt = 1'b0;
            state_nxt   = S_IDLE;
          end
        end else if (scan_idx_r < scan_n_r) begin
          t_re         = 1'b1;
          scan_idx_nxt = scan_idx_r + NW'(1);
          chk_vld_nxt  = 1'b1;
        end else if (chk_vld_r) begin
          chk_vld_nxt = 1'b0;
        end else begin
          // Scan passed: advance the epoch and pick the bin to reclaim.
          epoch_nxt   = epoch_r + EPOCH_W'(1);
          emod3_nxt   = (&epoch_r) ? 2'd0 : ((emod3_r == 2'd2) ? 2'd0 : emod3_r + 2'd1);
          matured_nxt = matured_r || (epoch_nxt >= EPOCH_W'(EPOCH_BINS));
          bin_nxt     = emod3_nxt;
          cnt_nxt     = matured_nxt ? fill_r[emod3_nxt] : '0;
          j_nxt       = '0;
          rd_pend_nxt = 1'b0;
          state_nxt   = S_DRAIN;
        end
      end
      // Emit the reclaimed handles in order, one read per result.
      S_DRAIN: begin
        ld_adv = 1'b1;
        if (cnt_r == '0) begin
          if (out_free) begin
            out_ld    = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (rd_pend_r) begin
          out_ld      = 1'b1;
          ld_fv       = 1'b1;
          ld_fh       = b_rdata;
          ld_last     = (j_r + FW'(1) == cnt_r);
          rd_pend_nxt = 1'b0;
          j_nxt       = j_r + FW'(1);
          if (ld_last) begin
            fill_nxt[bin_r] = '0;
            state_nxt       = S_IDLE;
          end
        end else if (out_free) begin
          b_re        = 1'b1;
          rd_pend_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      epoch_r     <= '0;
      emod3_r     <= 2'd0;
      matured_r   <= 1'b0;
      fill_r      <= '{default: '0};
      scan_idx_r  <= '0;
      scan_n_r    <= '0;
      chk_vld_r   <= 1'b0;
      bin_r       <= 2'd0;
      cnt_r       <= '0;
      j_r         <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      epoch_r     <= epoch_nxt;
      emod3_r     <= emod3_nxt;
      matured_r   <= matured_nxt;
      fill_r      <= fill_nxt;
      scan_idx_r  <= scan_idx_nxt;
      scan_n_r    <= scan_n_nxt;
      chk_vld_r   <= chk_vld_nxt;
      bin_r       <= bin_nxt;
      cnt_r       <= cnt_nxt;
      j_r         <= j_nxt;
      rd_pend_r   <= rd_pend_nxt;
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_status_r <= ld_status;
      out_adv_r    <= ld_adv;
      out_fv_r     <= ld_fv;
      out_fh_r     <= ld_fh;
      out_epoch_r  <= epoch_r;
      out_last_r   <= ld_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_advanced     = out_adv_r;
  assign out_freed_valid  = out_fv_r;
  assign out_freed_handle = HANDLE_PORT_W'(out_fh_r);
  assign out_epoch_now    = out_epoch_r;
  assign out_last         = out_last_r;
endmodule

/* hw/rtl/ert_checker.sv */
// Port checker for the reclamation tracker, bound to the top level.
`include "assert_macros.svh"
module ert_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [1:0]                        out_status,
  input logic                              out_advanced,
  input logic                              out_freed_valid,
  input logic [ert_pkg::HANDLE_PORT_W-1:0] out_freed_handle,
  input logic [ert_pkg::EPOCH_W-1:0]       out_epoch_now,
  input logic                              out_last
);
  import ert_pkg::*;

  // A refused request gives a single result that does not advance.
  `ERT_ASSERT(a_refuse_single, clk, rst_n, out_valid && out_status != ST_OK |-> out_last && !out_advanced && !out_freed_valid, "refusal not single")
  // A reclaimed handle only comes with a successful advance.
  `ERT_ASSERT(a_freed_adv, clk, rst_n, out_valid && out_freed_valid |-> out_advanced && out_status == ST_OK, "freed without advance")
  // Results of one drain carry the same epoch.
  `ERT_ASSERT(a_drain_epoch, clk, rst_n, out_valid && out_ready && out_freed_valid && !out_last ##1 out_valid |-> out_epoch_now == $past(out_epoch_now) || !out_freed_valid, "epoch changed in drain")
  // A stalled result holds.
  `ERT_ASSERT(a_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_freed_handle), "stalled result dropped")
endmodule

bind epoch_reclamation_tracker ert_checker u_ert_checker (.*);

/* test/epoch_reclamation_tracker_tb.sv */
// Self-checking testbench for the three-epoch reclamation tracker.
`timescale 1ns / 1ps

module epoch_reclamation_tracker_tb;
  import ert_pkg::*;

  localparam int NTHR = 128;
  localparam int BDEPTH = 32;
  localparam int WATCHDOG_LIMIT = 20000;

  // One request as queued for the driver.
  typedef struct {
    op_t         op;
    logic [6:0]  tid;
    logic [31:0] handle;
    logic        is_cfg;
    logic [7:0]  cfg_val;
  } req_item_t;

  // One expected result.
  typedef struct {
    status_t     status;
    logic        advanced;
    logic        freed_valid;
    logic [31:0] freed_handle;
    logic [31:0] epoch_now;
    logic        last;
  } res_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_mode = '0;
  logic [6:0] in_thread_id = '0;
  logic [31:0] in_handle = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic out_advanced;
  logic out_freed_valid;
  logic [31:0] out_freed_handle;
  logic [31:0] out_epoch_now;
  logic out_last;

  // Predictor state.
  logic [31:0] pr_epoch;
  logic        pr_matured;
  logic        pr_active[NTHR];
  logic [1:0]  pr_tmod[NTHR];
  int          pr_fill[3];
  logic [31:0] pr_bins[3][BDEPTH];
  logic [7:0]  pr_nthreads;

  req_item_t  pending_reqs[$];
  res_item_t  expected_results[$];
  int         mismatch_count = 0;
  int         accepted_reqs = 0;
  int         received_results = 0;
  int         freed_count = 0;
  int         idle_cycles = 0;
  bit         stim_done = 1'b0;
  int         burst_left = 0;
  int         gap_left = 0;
  logic [3:0] stall_pattern = 4'b1011;
  int         stall_phase = 0;

  epoch_reclamation_tracker i_dut (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_data,
    .in_valid, .in_ready, .in_mode, .in_thread_id, .in_handle,
    .out_valid, .out_ready, .out_status, .out_advanced, .out_freed_valid,
    .out_freed_handle, .out_epoch_now, .out_last
  );

  always #1 clk = ~clk;

  // Compute the results of one request and update the predictor state.
  function automatic void predict_tracker(req_item_t r);
    res_item_t e;
    int n;
    int b;
    bit lag;
    e = '{ST_OK, 1'b0, 1'b0, 32'd0, 32'd0, 1'b1};
    case (r.op)
      OP_ENTER, OP_EXIT: begin
        pr_active[r.tid] = (r.op == OP_ENTER);
        if (r.op == OP_ENTER) pr_tmod[r.tid] = pr_epoch[1:0];
      end
      OP_RETIRE: begin
        b = pr_epoch % 3;
        if (pr_fill[b] >= BDEPTH) begin
          e.status = ST_RETIRE_FULL;
        end else begin
          pr_bins[b][pr_fill[b]] = r.handle;
          pr_fill[b]++;
        end
      end
      default: begin
        n = (pr_nthreads > NTHR) ? NTHR : pr_nthreads;
        lag = 1'b0;
        for (int i = 0; i < n; i++)
          if (pr_active[i] && pr_tmod[i] != pr_epoch[1:0]) lag = 1'b1;
        if (lag) begin
          e.status = ST_ADV_REFUSED;
        end else begin
          pr_epoch = pr_epoch + 32'd1;
          if (pr_epoch >= 3) pr_matured = 1'b1;
          b = pr_epoch % 3;
          e.advanced = 1'b1;
          if (pr_matured && pr_fill[b] > 0) begin
            for (int i = 0; i < pr_fill[b]; i++) begin
              e.freed_valid = 1'b1;
              e.freed_handle = pr_bins[b][i];
              e.epoch_now = pr_epoch;
              e.last = (i + 1 == pr_fill[b]);
              expected_results.push_back(e);
            end
            pr_fill[b] = 0;
            return;
          end
        end
      end
    endcase
    e.epoch_now = pr_epoch;
    expected_results.push_back(e);
  endfunction

  function automatic req_item_t make_req(op_t op, int tid, logic [31:0] h);
    req_item_t r;
    r.op = op;
    r.tid = tid[6:0];
    r.handle = h;
    r.is_cfg = 1'b0;
    r.cfg_val = '0;
    return r;
  endfunction

  function automatic req_item_t make_cfg(logic [7:0] v);
    req_item_t r;
    r = make_req(OP_ENTER, 0, '0);
    r.is_cfg = 1'b1;
    r.cfg_val = v;
    return r;
  endfunction

  // Driver: sends queued requests in bursts; register writes wait for idle.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_tracker(pending_reqs.pop_front());
        accepted_reqs++;
      end
      if (cfg_valid && cfg_ready) begin
        pr_nthreads = cfg_data;
        void'(pending_reqs.pop_front());
      end
      if (!((in_valid && !in_ready) || (cfg_valid && !cfg_ready))) begin
        in_valid <= 1'b0;
        cfg_valid <= 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() > 0 && !(in_valid && in_ready)
                     && !(cfg_valid && cfg_ready) && pending_reqs[0].is_cfg) begin
          // Let the block settle before a register write.
          if (expected_results.size() == 0 && idle_cycles > 200) begin
            cfg_data <= pending_reqs[0].cfg_val;
            cfg_valid <= 1'b1;
          end
        end else if (pending_reqs.size() > 0 && !(cfg_valid && cfg_ready)) begin
          if (in_valid && in_ready && pending_reqs.size() > 0
              && pending_reqs[0].is_cfg) begin
            // Next entry is a register write; stop here.
          end else if (pending_reqs.size() > 0) begin
            in_valid <= 1'b1;
            in_mode <= pending_reqs[0].op;
            in_thread_id <= pending_reqs[0].tid;
            in_handle <= pending_reqs[0].handle;
            if (burst_left > 0) begin
              burst_left--;
            end else begin
              burst_left = $urandom_range(0, 12);
              gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            end
          end
        end
      end
    end
  end

  // Monitor: checks each result against the oldest expectation.
  always @(posedge clk) begin
    res_item_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        received_results++;
        if (expected_results.size() == 0) begin
          $error("unexpected result: epoch_now %0d", out_epoch_now);
          mismatch_count++;
        end else begin
          e = expected_results.pop_front();
          if (out_freed_valid) freed_count++;
          if (out_status != e.status) begin
            $error("status: expected %0d, actual %0d", e.status, out_status);
            mismatch_count++;
          end
          if (out_advanced != e.advanced) begin
            $error("advanced: expected %0d, actual %0d", e.advanced, out_advanced);
            mismatch_count++;
          end
          if (out_freed_valid != e.freed_valid) begin
            $error("freed_valid: expected %0d, actual %0d", e.freed_valid,
                   out_freed_valid);
            mismatch_count++;
          end
          if (out_freed_handle != e.freed_handle) begin
            $error("freed_handle: expected %h, actual %h", e.freed_handle,
                   out_freed_handle);
            mismatch_count++;
          end
          if (out_epoch_now != e.epoch_now) begin
            $error("epoch_now: expected %0d, actual %0d", e.epoch_now, out_epoch_now);
            mismatch_count++;
          end
          if (out_last != e.last) begin
            $error("last: expected %0d, actual %0d", e.last, out_last);
            mismatch_count++;
          end
        end
      end
      // Receiver stalls on a rotating pattern, with stall-free stretches.
      stall_phase++;
      if (stall_phase % 64 == 0) stall_pattern = $urandom_range(0, 15);
      out_ready <= (stall_phase % 128 < 40) ? 1'b1 : stall_pattern[stall_phase % 4];
    end
  end

  // Watchdog on cycles with no handshake of any kind.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Fill the request queue with directed and random phases.
  task automatic add_phase(int count, int tid_hi);
    int m;
    int t;
    for (int k = 0; k < count; k++) begin
      m = $urandom_range(0, 99);
      t = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, tid_hi);
      if (m < 25) pending_reqs.push_back(make_req(OP_ENTER, t, $urandom));
      else if (m < 50) pending_reqs.push_back(make_req(OP_EXIT, t, $urandom));
      else if (m < 80) pending_reqs.push_back(make_req(OP_RETIRE, t, $urandom));
      else pending_reqs.push_back(make_req(OP_ADVANCE, t, $urandom));
    end
  endtask

  initial begin
    pr_epoch = '0;
    pr_matured = 1'b0;
    pr_nthreads = '0;
    for (int i = 0; i < NTHR; i++) begin
      pr_active[i] = 1'b0;
      pr_tmod[i] = '0;
    end
    for (int i = 0; i < 3; i++) pr_fill[i] = 0;

    // Directed: fill a bin past full, advance through maturity, lag refusal.
    pending_reqs.push_back(make_cfg(8'd255));
    for (int k = 0; k < 33; k++)
      pending_reqs.push_back(make_req(OP_RETIRE, 0, (k == 0) ? 32'hFFFF_FFFF : k));
    pending_reqs.push_back(make_req(OP_ENTER, 127, 32'h0));
    pending_reqs.push_back(make_req(OP_ENTER, 0, 32'h0));
    pending_reqs.push_back(make_req(OP_ADVANCE, 0, 32'h0));
    pending_reqs.push_back(make_req(OP_EXIT, 0, 32'h0));
    pending_reqs.push_back(make_req(OP_ADVANCE, 127, 32'h0));
    pending_reqs.push_back(make_req(OP_EXIT, 127, 32'h0));
    pending_reqs.push_back(make_req(OP_RETIRE, 5, 32'h8000_0001));
    for (int k = 0; k < 4; k++) pending_reqs.push_back(make_req(OP_ADVANCE, 0, 32'h0));

    // Random phases over several thread counts, extremes included.
    pending_reqs.push_back(make_cfg(8'd0));
    add_phase(45, 127);
    pending_reqs.push_back(make_cfg(8'd128));
    add_phase(40, 127);
    pending_reqs.push_back(make_cfg(8'd4));
    add_phase(60, 7);
    pending_reqs.push_back(make_cfg(8'd200));
    add_phase(35, 3);
    pending_reqs.push_back(make_cfg(8'd16));
    add_phase(37, 20);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_reqs.size() == 0);
    wait (expected_results.size() == 0);
    repeat (300) @(posedge clk);
    $display("Accepted %0d requests, checked %0d results, %0d reclaimed handles.",
             accepted_reqs, received_results, freed_count);
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule
